// ----- design/skm_pkg.sv -----
// ----------------------------------------------------------------------------
// skm_pkg
// shared types and constants of the stable k-way merge block
// ----------------------------------------------------------------------------
package skm_pkg;

    // default sizes handed to the top level parameters
    localparam int DEF_MAX_SOURCES   = 16;
    localparam int DEF_KEY_WIDTH     = 32;
    localparam int DEF_PAYLOAD_WIDTH = 32;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_NUM_SOURCES = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DESCENDING  = 1'd1;
    localparam logic [CFG_DATA_W-1:0]  NUM_SOURCES_RESET = 5'd2;

    // input action codes
    typedef enum logic [1:0] {
        ACT_ITEM    = 2'd0,
        ACT_END     = 2'd1,
        ACT_RESTART = 2'd2,
        ACT_UNUSED  = 2'd3
    } t_action;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DROP,
        S_INSERT,
        S_EMIT
    } t_state;

    // operation broadcast to every cell of the store
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DROP,
        CELL_INSERT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     descending;
    } t_cell_ctrl;

endpackage

// ----- design/stable_kway_merge.sv -----
// ----------------------------------------------------------------------------
// stable_kway_merge
// stable merge of up to MAX_SOURCES pre-sorted sources through a row of cells
// ----------------------------------------------------------------------------
// After reset or a restart item the block takes one head item (action 0) or
// end mark (action 1) per source, for sources 0 to num_sources-1 in order;
// the last of these gives the first result. From then on every result names
// in o_out_source the source that must deliver the next item or end mark;
// status 1 means no source is left and repeats for every further item.
// Ties between equal keys go to the lower source. Live heads sit in a row of
// MAX_SOURCES cells, head first; each cell compares the incoming head with
// its own and the whole row shifts one place together. An item is accepted
// in the idle state, then passes through the store operations it needs and
// the load of the result: an insert for a fill item with no result, nothing
// for a fill end mark with no result, insert and load for the last fill item
// (load alone when it is an end mark), drop, insert of the successor and
// load for a replace during the merge, drop and load for an end mark, load
// alone for a done report once the store is empty. Restart and unused action
// items take no further step. The load waits as long as an earlier result
// still sits in the output register. The critical path is the key compare in
// each cell followed by the found chain that ripples down the row.
// ----------------------------------------------------------------------------
module stable_kway_merge
    import skm_pkg::*;
#(
    parameter int MAX_SOURCES   = DEF_MAX_SOURCES,
    parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    // input items
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_action,
    input  logic [KEY_WIDTH-1:0]          i_sort_key,
    input  logic [PAYLOAD_WIDTH-1:0]      i_payload,
    // result items
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_status,
    output logic [KEY_WIDTH-1:0]          o_out_key,
    output logic [PAYLOAD_WIDTH-1:0]      o_out_payload,
    output logic [$clog2(MAX_SOURCES)-1:0] o_out_source
);

    localparam int SRC_W = $clog2(MAX_SOURCES);
    localparam int CNT_W = $clog2(MAX_SOURCES + 1);
    // wide enough for both the register value and the source count
    localparam int CMP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    // configuration registers
    logic [CFG_DATA_W-1:0]    r_num_sources;
    logic                     r_descending;

    // sequencer state
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_fill;
    logic                     r_filling;
    logic                     r_do_ins;
    logic                     r_do_emit;

    // captured item for the insert
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [SRC_W-1:0]         r_source;

    // output register
    logic                     r_out_valid;
    logic                     r_status;
    logic [KEY_WIDTH-1:0]     r_out_key;
    logic [PAYLOAD_WIDTH-1:0] r_out_payload;
    logic [SRC_W-1:0]         r_out_source;

    // row wiring
    t_cell_ctrl               cell_ctrl;
    logic [MAX_SOURCES:0]     found;
    logic [KEY_WIDTH-1:0]     cell_key     [MAX_SOURCES];
    logic [PAYLOAD_WIDTH-1:0] cell_payload [MAX_SOURCES];
    logic [SRC_W-1:0]         cell_source  [MAX_SOURCES];

    logic                     in_fire;
    logic                     out_load;
    logic                     full;
    t_action                  act;
    logic [CMP_W-1:0]         num_raw;
    logic [CMP_W-1:0]         num_eff;
    logic                     fill_last;
    logic                     go_drop;
    logic                     go_ins;
    logic                     go_emit;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign out_load    = !r_out_valid || i_ready;
    assign full        = r_count == CNT_W'(MAX_SOURCES);
    assign act         = t_action'(i_action);

    // clamp the source count into 1..MAX_SOURCES
    always_comb begin
        num_raw = CMP_W'(r_num_sources);
        if (num_raw == '0) begin
            num_eff = CMP_W'(1);
        end else if (num_raw > CMP_W'(MAX_SOURCES)) begin
            num_eff = CMP_W'(MAX_SOURCES);
        end else begin
            num_eff = num_raw;
        end
    end

    // fill ends once the count of delivered heads reaches the source count
    assign fill_last = ({1'b0, CMP_W'(r_fill)} + (CMP_W + 1)'(1)) >= {1'b0, num_eff};

    // what the accepted item needs
    assign go_drop = !r_filling && (r_count != '0);
    assign go_ins  = (act == ACT_ITEM) && (r_filling || (r_count != '0));
    assign go_emit = r_filling ? fill_last : 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sources <= NUM_SOURCES_RESET;
            r_descending  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_SOURCES: r_num_sources <= i_cfg_data;
                CFG_DESCENDING:  r_descending  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // next state and cell operation
    always_comb begin
        n_state              = r_state;
        cell_ctrl.op         = CELL_HOLD;
        cell_ctrl.descending = r_descending;
        o_ready              = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (in_fire && (act == ACT_ITEM || act == ACT_END)) begin
                    if (go_drop) begin
                        n_state = S_DROP;
                    end else if (go_ins) begin
                        n_state = S_INSERT;
                    end else if (go_emit) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_DROP: begin
                cell_ctrl.op = CELL_DROP;
                n_state      = r_do_ins ? S_INSERT : S_EMIT;
            end
            S_INSERT: begin
                // a full store ignores the insert
                cell_ctrl.op = full ? CELL_HOLD : CELL_INSERT;
                n_state      = r_do_emit ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // store bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_fill    <= '0;
            r_filling <= 1'b1;
            r_do_ins  <= 1'b0;
            r_do_emit <= 1'b0;
        end else begin
            if (in_fire) begin
                case (act)
                    ACT_RESTART: begin
                        r_count   <= '0;
                        r_fill    <= '0;
                        r_filling <= 1'b1;
                    end
                    ACT_ITEM, ACT_END: begin
                        r_do_ins  <= go_ins;
                        r_do_emit <= go_emit;
                        if (r_filling) begin
                            r_fill <= r_fill + CNT_W'(1);
                            if (fill_last) begin
                                r_filling <= 1'b0;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            case (cell_ctrl.op)
                CELL_DROP:   r_count <= r_count - CNT_W'(1);
                CELL_INSERT: r_count <= r_count + CNT_W'(1);
                default: begin
                end
            endcase
        end
    end

    // item for the insert: fill source during start-up, else the head's source
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key     <= i_sort_key;
            r_payload <= i_payload;
            r_source  <= r_filling ? r_fill[SRC_W-1:0] : cell_source[0];
        end
    end

    // row of cells, head at index 0
    assign found[0] = 1'b0;

    for (genvar gi = 0; gi < MAX_SOURCES; gi++) begin : g_cell
        logic [KEY_WIDTH-1:0]     prev_key,     next_key;
        logic [PAYLOAD_WIDTH-1:0] prev_payload, next_payload;
        logic [SRC_W-1:0]         prev_source,  next_source;

        if (gi == 0) begin : g_first
            assign prev_key     = '0;
            assign prev_payload = '0;
            assign prev_source  = '0;
        end else begin : g_inner
            assign prev_key     = cell_key[gi-1];
            assign prev_payload = cell_payload[gi-1];
            assign prev_source  = cell_source[gi-1];
        end

        if (gi == MAX_SOURCES - 1) begin : g_last
            assign next_key     = '0;
            assign next_payload = '0;
            assign next_source  = '0;
        end else begin : g_body
            assign next_key     = cell_key[gi+1];
            assign next_payload = cell_payload[gi+1];
            assign next_source  = cell_source[gi+1];
        end

        skm_cell #(
            .IDX          (gi),
            .KEY_WIDTH    (KEY_WIDTH),
            .PAYLOAD_WIDTH(PAYLOAD_WIDTH),
            .SRC_W        (SRC_W),
            .CNT_W        (CNT_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (cell_ctrl),
            .i_count       (r_count),
            .i_found       (found[gi]),
            .o_found       (found[gi+1]),
            .i_new_key     (r_key),
            .i_new_payload (r_payload),
            .i_new_source  (r_source),
            .i_prev_key    (prev_key),
            .i_prev_payload(prev_payload),
            .i_prev_source (prev_source),
            .i_next_key    (next_key),
            .i_next_payload(next_payload),
            .i_next_source (next_source),
            .o_key         (cell_key[gi]),
            .o_payload     (cell_payload[gi]),
            .o_source      (cell_source[gi])
        );
    end

    // output register: head of the store, or done once the store is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_load) begin
            if (r_count == '0) begin
                r_status      <= 1'b1;
                r_out_key     <= '0;
                r_out_payload <= '0;
                r_out_source  <= '0;
            end else begin
                r_status      <= 1'b0;
                r_out_key     <= cell_key[0];
                r_out_payload <= cell_payload[0];
                r_out_source  <= cell_source[0];
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_out_key     = r_out_key;
    assign o_out_payload = r_out_payload;
    assign o_out_source  = r_out_source;

endmodule

// ----- design/skm_cell.sv -----
// ----------------------------------------------------------------------------
// skm_cell
// one entry of the ordered head store: holds key, payload and source,
// shifts toward the head on a drop and makes room on an insert
// ----------------------------------------------------------------------------
module skm_cell
    import skm_pkg::*;
#(
    parameter int IDX           = 0,
    parameter int KEY_WIDTH     = DEF_KEY_WIDTH,
    parameter int PAYLOAD_WIDTH = DEF_PAYLOAD_WIDTH,
    parameter int SRC_W         = 4,
    parameter int CNT_W         = 5
) (
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic [CNT_W-1:0]         i_count,
    input  logic                     i_found,
    output logic                     o_found,
    input  logic [KEY_WIDTH-1:0]     i_new_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_new_payload,
    input  logic [SRC_W-1:0]         i_new_source,
    input  logic [KEY_WIDTH-1:0]     i_prev_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_prev_payload,
    input  logic [SRC_W-1:0]         i_prev_source,
    input  logic [KEY_WIDTH-1:0]     i_next_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_next_payload,
    input  logic [SRC_W-1:0]         i_next_source,
    output logic [KEY_WIDTH-1:0]     o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload,
    output logic [SRC_W-1:0]         o_source
);

    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [SRC_W-1:0]         r_source;
    logic                     live;
    logic                     new_ahead;
    logic                     slot;

    // new head leaves before this one: key order first, lower source on a tie
    always_comb begin
        if (i_new_key != r_key) begin
            if (i_ctrl.descending) begin
                new_ahead = $signed(i_new_key) > $signed(r_key);
            end else begin
                new_ahead = $signed(i_new_key) < $signed(r_key);
            end
        end else begin
            new_ahead = i_new_source < r_source;
        end
    end

    assign live    = CNT_W'(IDX) < i_count;
    assign slot    = !live || new_ahead;
    assign o_found = i_found || slot;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            CELL_DROP: begin
                r_key     <= i_next_key;
                r_payload <= i_next_payload;
                r_source  <= i_next_source;
            end
            CELL_INSERT: begin
                if (i_found) begin
                    r_key     <= i_prev_key;
                    r_payload <= i_prev_payload;
                    r_source  <= i_prev_source;
                end else if (slot) begin
                    r_key     <= i_new_key;
                    r_payload <= i_new_payload;
                    r_source  <= i_new_source;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_source  = r_source;

endmodule
